// ===== rtl/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, codes and reset values for the safety speed governor.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER_DEC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_FLOOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_HOLD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd5;

  // Register reset values.
  localparam logic [15:0] STEP_PERIOD_RST    = 16'd1000;
  localparam logic [6:0]  DANGER_DEC_RST     = 7'd10;
  localparam logic [6:0]  WARNING_FLOOR_RST  = 7'd30;
  localparam logic [15:0] SAFE_HOLD_RST      = 16'd3000;
  localparam logic [15:0] RECOVER_PERIOD_RST = 16'd200;
  localparam logic [6:0]  MAX_SPEED_RST      = 7'd80;

  // Action codes.
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Monitor codes for temperature, gas and current.
  localparam logic [1:0] MON_WARN   = 2'd1;
  localparam logic [1:0] MON_DANGER = 2'd2;

  // Voltage monitor codes.
  localparam logic [2:0] VOLT_UNDER_WARN   = 3'd1;
  localparam logic [2:0] VOLT_OVER_WARN    = 3'd2;
  localparam logic [2:0] VOLT_UNDER_DANGER = 3'd3;
  localparam logic [2:0] VOLT_OVER_DANGER  = 3'd4;

  // Reduction per period by number of warning groups.
  localparam logic [2:0] STEP_NONE  = 3'd0;
  localparam logic [2:0] STEP_ONE   = 3'd1;
  localparam logic [2:0] STEP_TWO   = 3'd3;
  localparam logic [2:0] STEP_THREE = 3'd5;

  typedef struct packed {
    logic              action;
    logic [31:0]       now_ms;
    logic [7:0]        measured_speed;
    logic signed [7:0] speed_in;
    logic [1:0]        temp_state;
    logic [1:0]        gas_state;
    logic [1:0]        current_state;
    logic [2:0]        voltage_state;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] speed_out;
    logic [1:0]        warn_groups;
    logic [2:0]        cut_step;
    logic              latched;
    logic [4:0]        reason_mask;
  } out_item_t;

  typedef struct packed {
    logic [15:0] step_period_ms;
    logic [6:0]  danger_decrement;
    logic [6:0]  warning_floor;
    logic [15:0] safe_hold_ms;
    logic [15:0] recover_period_ms;
    logic [6:0]  max_speed;
  } cfg_t;

  typedef struct packed {
    logic       flag;
    logic [4:0] cause;
  } danger_t;

  function automatic logic [2:0] reduction_for(input logic [1:0] count);
    logic [2:0] step;
    unique case (count)
      2'd0:    step = STEP_NONE;
      2'd1:    step = STEP_ONE;
      2'd2:    step = STEP_TWO;
      default: step = STEP_THREE;
    endcase
    return step;
  endfunction

endpackage

// ===== rtl/safety_speed_governor_core.sv =====
// ----------------------------------------------------------------------------
// safety_speed_governor_core
// Speed governor that limits the commanded speed from monitor states.
// ----------------------------------------------------------------------------
// Usage: each input item carries an action, a millisecond tick, the measured
// and commanded speeds and four monitor states; every item yields exactly one
// result item with the governed speed, warning count, reduction step, danger
// latch and latched reason mask.
// Channels: in_valid/in_ready and out_valid/out_ready, payloads as packed
// structs. The configuration port writes one register per cycle when cfg_we
// is high; the user must write it only while no item is in flight, and
// the block does not enforce this. An accepted item waits in the input
// register until the result register is free, then is loaded into it and
// out_valid rises. Throughput is one item per cycle while results are taken,
// set by the single update stage that reads and writes the timers and the latch.
// A stalled receiver holds the result register; the input register still
// takes one more item, after which in_ready falls until the result is taken.
// Synchronous reset empties both registers, loads the register defaults and
// clears the timers, the latch and the reason mask.
// ----------------------------------------------------------------------------
module safety_speed_governor_core #(
  parameter int unsigned TICK_WIDTH = ssg_pkg::TICK_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ssg_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ssg_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [ssg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                  in_v_r;
  ssg_pkg::in_item_t     in_item_r;
  logic                  out_v_r;
  ssg_pkg::out_item_t    out_item_r;
  ssg_pkg::cfg_t         cfg_r, cfg_nxt;
  ssg_pkg::danger_t      danger_r, danger_nxt;
  logic [TICK_WIDTH-1:0] last_step_r, last_step_nxt;
  logic [TICK_WIDTH-1:0] last_warn_r, last_warn_nxt;
  logic [TICK_WIDTH-1:0] last_recover_r, last_recover_nxt;
  ssg_pkg::out_item_t    result;
  logic                  advance;

  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  ssg_eval #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_eval (
    .item             (in_item_r),
    .cfg              (cfg_r),
    .danger           (danger_r),
    .last_step        (last_step_r),
    .last_warn        (last_warn_r),
    .last_recover     (last_recover_r),
    .result           (result),
    .danger_nxt       (danger_nxt),
    .last_step_nxt    (last_step_nxt),
    .last_warn_nxt    (last_warn_nxt),
    .last_recover_nxt (last_recover_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ssg_pkg::REG_STEP_PERIOD:    cfg_nxt.step_period_ms    = cfg_wdata;
        ssg_pkg::REG_DANGER_DEC:     cfg_nxt.danger_decrement  = cfg_wdata[6:0];
        ssg_pkg::REG_WARNING_FLOOR:  cfg_nxt.warning_floor     = cfg_wdata[6:0];
        ssg_pkg::REG_SAFE_HOLD:      cfg_nxt.safe_hold_ms      = cfg_wdata;
        ssg_pkg::REG_RECOVER_PERIOD: cfg_nxt.recover_period_ms = cfg_wdata;
        ssg_pkg::REG_MAX_SPEED:      cfg_nxt.max_speed         = cfg_wdata[6:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period_ms    <= ssg_pkg::STEP_PERIOD_RST;
      cfg_r.danger_decrement  <= ssg_pkg::DANGER_DEC_RST;
      cfg_r.warning_floor     <= ssg_pkg::WARNING_FLOOR_RST;
      cfg_r.safe_hold_ms      <= ssg_pkg::SAFE_HOLD_RST;
      cfg_r.recover_period_ms <= ssg_pkg::RECOVER_PERIOD_RST;
      cfg_r.max_speed         <= ssg_pkg::MAX_SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake and governor state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      danger_r       <= '0;
      last_step_r    <= '0;
      last_warn_r    <= '0;
      last_recover_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r        <= 1'b1;
        danger_r       <= danger_nxt;
        last_step_r    <= last_step_nxt;
        last_warn_r    <= last_warn_nxt;
        last_recover_r <= last_recover_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule

// ===== rtl/ssg_eval.sv =====
// ----------------------------------------------------------------------------
// ssg_eval
// Combinational update of one item: classifies the monitors, applies the clear,
// standstill, danger, warning or recovery rule and produces the next governor state.
// ----------------------------------------------------------------------------
module ssg_eval #(
  parameter int unsigned TICK_WIDTH = ssg_pkg::TICK_WIDTH_DEF
) (
  input  ssg_pkg::in_item_t      item,
  input  ssg_pkg::cfg_t          cfg,
  input  ssg_pkg::danger_t       danger,
  input  logic [TICK_WIDTH-1:0]  last_step,
  input  logic [TICK_WIDTH-1:0]  last_warn,
  input  logic [TICK_WIDTH-1:0]  last_recover,
  output ssg_pkg::out_item_t     result,
  output ssg_pkg::danger_t       danger_nxt,
  output logic [TICK_WIDTH-1:0]  last_step_nxt,
  output logic [TICK_WIDTH-1:0]  last_warn_nxt,
  output logic [TICK_WIDTH-1:0]  last_recover_nxt
);

  logic [TICK_WIDTH-1:0] now;
  logic [TICK_WIDTH-1:0] warn_base;
  logic                  w_temp, w_gas, w_elec;
  logic [1:0]            wcount;
  logic [2:0]            step;
  logic [4:0]            cause;
  logic                  step_due, hold_ok, recover_due;
  logic signed [8:0]     spd9, dec9, floor9, floor_step9, max9;
  logic signed [8:0]     spd_dec9, spd_step9, spd_inc9;

  assign now = TICK_WIDTH'(item.now_ms);

  assign w_temp = (item.temp_state == ssg_pkg::MON_WARN);
  assign w_gas  = (item.gas_state == ssg_pkg::MON_WARN);
  assign w_elec = (item.current_state == ssg_pkg::MON_WARN)
               || (item.voltage_state == ssg_pkg::VOLT_UNDER_WARN)
               || (item.voltage_state == ssg_pkg::VOLT_OVER_WARN);
  assign wcount = 2'(w_temp) + 2'(w_gas) + 2'(w_elec);
  assign step   = ssg_pkg::reduction_for(wcount);

  assign cause = {item.voltage_state == ssg_pkg::VOLT_UNDER_DANGER,
                  item.voltage_state == ssg_pkg::VOLT_OVER_DANGER,
                  item.current_state == ssg_pkg::MON_DANGER,
                  item.gas_state == ssg_pkg::MON_DANGER,
                  item.temp_state == ssg_pkg::MON_DANGER};

  // A zero warning timer counts as unset while no warning is active.
  assign warn_base = (last_warn == '0) ? now : last_warn;

  // Tick differences wrap at the tick width.
  assign step_due    = (TICK_WIDTH'(now - last_step) >= TICK_WIDTH'(cfg.step_period_ms));
  assign hold_ok     = (TICK_WIDTH'(now - warn_base) >= TICK_WIDTH'(cfg.safe_hold_ms));
  assign recover_due = (TICK_WIDTH'(now - last_recover)
                        >= TICK_WIDTH'(cfg.recover_period_ms));

  assign spd9        = {item.speed_in[7], item.speed_in};
  assign dec9        = $signed({2'b00, cfg.danger_decrement});
  assign floor9      = $signed({2'b00, cfg.warning_floor});
  assign floor_step9 = floor9 + $signed({6'b000000, step});
  assign max9        = $signed({2'b00, cfg.max_speed});
  assign spd_dec9    = spd9 - dec9;
  assign spd_step9   = spd9 - $signed({6'b000000, step});
  assign spd_inc9    = spd9 + 9'sd1;

  always_comb begin
    danger_nxt       = danger;
    last_step_nxt    = last_step;
    last_warn_nxt    = last_warn;
    last_recover_nxt = last_recover;
    result.speed_out   = item.speed_in;
    result.warn_groups = wcount;
    result.cut_step    = step;

    if (item.action == ssg_pkg::ACT_CLEAR) begin
      danger_nxt         = '0;
      result.warn_groups = '0;
      result.cut_step    = ssg_pkg::STEP_NONE;
    end else if (item.measured_speed == 8'd0) begin
      last_step_nxt = now;
      last_warn_nxt = now;
    end else begin
      if (cause != 5'd0) begin
        if (!danger.flag) begin
          danger_nxt.cause = cause;
        end
        danger_nxt.flag = 1'b1;
      end
      if (danger_nxt.flag) begin
        if (step_due) begin
          last_step_nxt = now;
          if (spd9 > dec9) begin
            result.speed_out = spd_dec9[7:0];
          end else begin
            result.speed_out = '0;
          end
        end
      end else if (wcount != 2'd0) begin
        last_warn_nxt    = now;
        last_recover_nxt = now;
        if (step_due) begin
          last_step_nxt = now;
          if (spd9 > floor_step9) begin
            result.speed_out = spd_step9[7:0];
          end else begin
            result.speed_out = floor9[7:0];
          end
        end
      end else begin
        last_warn_nxt = warn_base;
        if (hold_ok && recover_due) begin
          last_recover_nxt = now;
          if (spd9 < max9) begin
            result.speed_out = spd_inc9[7:0];
          end
        end
        last_step_nxt = now;
      end
    end

    result.latched     = danger_nxt.flag;
    result.reason_mask = danger_nxt.cause;
  end

endmodule
